### design/kms_pkg.sv
// Package for the k-way merge selector.
// Holds the field widths, parameter defaults and the cell control word.
// No dependencies.
`default_nettype none

package kms_pkg;

	localparam int VALUE_W      = 64;
	localparam int SRC_W        = 4;
	localparam int NUM_RUNS_W   = 5;
	localparam int MAX_RUNS_DEF = 16;

	// Command that every cell of the sorted chain sees in the same cycle.
	typedef struct packed {
		logic ins;  // insert the new head at its sorted place
		logic pop;  // shift every entry one cell toward the front
		logic clr;  // drop all entries held so far
	} cell_ctrl_t;

endpackage

`default_nettype wire

### design/kms_cell.sv
// One cell of the sorted chain of heads used by the k-way merge selector.
// Holds one (value, run) entry; depends on kms_pkg.
`default_nettype none

module kms_cell #(
	parameter int RUN_W = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  kms_pkg::cell_ctrl_t          ctrl,
	input  wire [kms_pkg::VALUE_W-1:0]   new_value,
	input  wire [RUN_W-1:0]              new_run,
	input  wire                          left_take,
	input  wire                          left_valid,
	input  wire [kms_pkg::VALUE_W-1:0]   left_value,
	input  wire [RUN_W-1:0]              left_run,
	input  wire                          right_valid,
	input  wire [kms_pkg::VALUE_W-1:0]   right_value,
	input  wire [RUN_W-1:0]              right_run,
	output logic                         take,
	output logic                         valid,
	output logic [kms_pkg::VALUE_W-1:0]  value,
	output logic [RUN_W-1:0]             run
);

	logic                        valid_q;
	logic [kms_pkg::VALUE_W-1:0] value_q;
	logic [RUN_W-1:0]            run_q;
	logic                        new_less;

	// Ties on value are broken by the lower run number.
	assign new_less = ($signed(new_value) < $signed(value_q)) ||
		((new_value == value_q) && (new_run < run_q));

	// The new entry belongs at or before this cell.
	assign take = ctrl.clr || !valid_q || new_less;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.ins && take) begin
			valid_q <= left_take ? (left_valid && !ctrl.clr) : 1'b1;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= right_value;
			run_q   <= right_run;
		end else if (ctrl.ins && take) begin
			value_q <= left_take ? left_value : new_value;
			run_q   <= left_take ? left_run : new_run;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign run   = run_q;

endmodule

`default_nettype wire

### design/kway_merge_selector.sv
// Top level of the k-way merge selector: control sequencer and the sorted cell chain.
// Depends on kms_pkg and kms_cell.
//
// Usage: set num_runs on the cfg channel (one word, written while idle; 0 acts as 1).
// Then send one word per run on s_axis, runs 0 to num_runs-1 in order: tdata is the
// run's first element, tuser[0] flags an empty run. After the last load word, and
// after every following refill word, one result word appears on m_axis: the smallest
// head in tdata, its run in tuser[3:0] with tuser[4] low. The next input word is the
// refill of that run. When no heads remain the result has tuser[4] high and the block
// returns to the load phase.
// Heads sit in a chain of MAX_RUNS cells kept sorted by (value, run); an insert puts a
// word in place in the cycle it is accepted. After a refill or the last load word the
// block moves to its emit step, which registers the front cell as the result and shifts
// the chain once the output register is free; insert and pop thus use the chain in turn,
// and no input word is taken until the emit step is done. Other load words skip it.
// The output register holds a result until taken; while it is full and not drained the
// block waits in its emit step and accepts no input. Reset empties the chain, returns
// to the load phase and sets num_runs to 1.
`default_nettype none

module kway_merge_selector #(
	parameter int MAX_RUNS = kms_pkg::MAX_RUNS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [kms_pkg::NUM_RUNS_W-1:0]     cfg_data,       // num_runs
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire [kms_pkg::VALUE_W-1:0]        s_axis_tdata,   // value
	input  wire [0:0]                         s_axis_tuser,   // run_empty
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [kms_pkg::VALUE_W-1:0]       m_axis_tdata,   // value_res
	output logic [kms_pkg::SRC_W:0]           m_axis_tuser    // source_run[3:0], done_res
);

	localparam int RUN_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CNT_A = $clog2(MAX_RUNS + 1);
	localparam int CNT_W = (CNT_A > kms_pkg::NUM_RUNS_W) ? CNT_A : kms_pkg::NUM_RUNS_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                             state_q;
	logic                             merging_q;
	logic [RUN_W-1:0]                 load_index_q;
	logic [RUN_W-1:0]                 awaited_q;
	logic [kms_pkg::NUM_RUNS_W-1:0]   num_runs_q;

	logic                             out_valid_q;
	logic [kms_pkg::VALUE_W-1:0]      out_value_q;
	logic [kms_pkg::SRC_W-1:0]        out_src_q;
	logic                             out_done_q;

	logic                             in_accept;
	logic                             out_free;
	logic                             last_load;
	logic [CNT_W-1:0]                 slot_next;
	kms_pkg::cell_ctrl_t              ctrl;
	logic [RUN_W-1:0]                 new_run;

	logic                             cell_valid [MAX_RUNS];
	logic [kms_pkg::VALUE_W-1:0]      cell_value [MAX_RUNS];
	logic [RUN_W-1:0]                 cell_run   [MAX_RUNS];
	logic [MAX_RUNS-1:0]              cell_take;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// A run count of zero ends the load at run 0, as a count of one does.
	assign slot_next = CNT_W'(load_index_q) + CNT_W'(1);
	assign last_load = (slot_next >= CNT_W'(num_runs_q)) ||
		(slot_next >= CNT_W'(MAX_RUNS));

	assign new_run  = merging_q ? awaited_q : load_index_q;
	assign ctrl.ins = in_accept && !s_axis_tuser[0];
	assign ctrl.clr = in_accept && !merging_q && (load_index_q == '0);
	assign ctrl.pop = (state_q == ST_EMIT) && out_free && cell_valid[0];

	for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
		logic                        l_take;
		logic                        l_valid;
		logic [kms_pkg::VALUE_W-1:0] l_value;
		logic [RUN_W-1:0]            l_run;
		logic                        r_valid;
		logic [kms_pkg::VALUE_W-1:0] r_value;
		logic [RUN_W-1:0]            r_run;

		if (i == 0) begin : g_first
			assign l_take  = 1'b0;
			assign l_valid = 1'b0;
			assign l_value = '0;
			assign l_run   = '0;
		end else begin : g_mid
			assign l_take  = cell_take[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_value = cell_value[i-1];
			assign l_run   = cell_run[i-1];
		end

		if (i == MAX_RUNS - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_value = '0;
			assign r_run   = '0;
		end else begin : g_inner
			assign r_valid = cell_valid[i+1];
			assign r_value = cell_value[i+1];
			assign r_run   = cell_run[i+1];
		end

		kms_cell #(
			.RUN_W(RUN_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (s_axis_tdata),
			.new_run    (new_run),
			.left_take  (l_take),
			.left_valid (l_valid),
			.left_value (l_value),
			.left_run   (l_run),
			.right_valid(r_valid),
			.right_value(r_value),
			.right_run  (r_run),
			.take       (cell_take[i]),
			.valid      (cell_valid[i]),
			.value      (cell_value[i]),
			.run        (cell_run[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_runs_q <= kms_pkg::NUM_RUNS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			num_runs_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			merging_q    <= 1'b0;
			load_index_q <= '0;
			awaited_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (merging_q || last_load) begin
							state_q      <= ST_EMIT;
							merging_q    <= 1'b1;
							load_index_q <= '0;
						end else begin
							load_index_q <= slot_next[RUN_W-1:0];
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (cell_valid[0]) begin
							awaited_q <= cell_run[0];
						end else begin
							merging_q    <= 1'b0;
							load_index_q <= '0;
							awaited_q    <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			if (cell_valid[0]) begin
				out_value_q <= cell_value[0];
				out_src_q   <= kms_pkg::SRC_W'(cell_run[0]);
				out_done_q  <= 1'b0;
			end else begin
				out_value_q <= '0;
				out_src_q   <= '0;
				out_done_q  <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = {out_done_q, out_src_q};

endmodule

`default_nettype wire
